/* hw/rtl/block_batch_ring_log_assert.svh */
// assertion macros for the block batch ring log port checker
`ifndef BLOCK_BATCH_RING_LOG_ASSERT_SVH
`define BLOCK_BATCH_RING_LOG_ASSERT_SVH

// same-cycle implication
`define BBRL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BBRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bbrl_pkg.sv */
// shared types and constants of the block batch ring log
package bbrl_pkg;

  localparam int unsigned BLK_W      = 64;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 224;
  localparam int unsigned MOD_STEP   = 4;

  localparam logic [BLK_W-1:0] NO_BLOCK = '1;

  localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
  localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJ  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DROP = 2'd3;

  typedef struct packed {
    logic wr;
    logic clr;
    logic clr_all;
  } slot_ctl_t;

endpackage

/* hw/rtl/bbrl_mod.sv */
// iterative remainder unit: block number modulo the slot count
module bbrl_mod #(
  parameter int unsigned DIVISOR = 64,
  localparam int unsigned RW = $clog2(DIVISOR)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bbrl_pkg::BLK_W-1:0] value,
  output logic                     done,
  output logic [RW-1:0]            rem
);

  localparam bit          POW2  = (DIVISOR & (DIVISOR - 1)) == 0;
  localparam int unsigned NSTEP = bbrl_pkg::BLK_W / bbrl_pkg::MOD_STEP;
  localparam int unsigned SCW   = $clog2(NSTEP + 1);

  logic [bbrl_pkg::BLK_W-1:0] val_r;
  logic [RW-1:0]              rem_r, rem_nxt;
  logic [SCW-1:0]             step_r;
  logic                       busy_r, done_r;

  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] r;
    r = rem_r;
    for (int i = 0; i < int'(bbrl_pkg::MOD_STEP); i++) begin
      t = {r, val_r[bbrl_pkg::BLK_W-1-i]};
      if (t >= (RW+1)'(DIVISOR)) begin
        t = t - (RW+1)'(DIVISOR);
      end
      r = t[RW-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (POW2) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          step_r <= SCW'(NSTEP);
        end
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == SCW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      rem_r <= POW2 ? value[RW-1:0] : '0;
    end else if (busy_r) begin
      val_r <= val_r << bbrl_pkg::MOD_STEP;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/bbrl_slot_tbl.sv */
// slot table: block, start and size memories with per-slot valid bits
module bbrl_slot_tbl #(
  parameter int unsigned SLOT_COUNT = 64,
  parameter int unsigned RING_RECORDS = 4096,
  localparam int unsigned SW = $clog2(SLOT_COUNT),
  localparam int unsigned AW = $clog2(RING_RECORDS),
  localparam int unsigned FW = $clog2(RING_RECORDS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bbrl_pkg::slot_ctl_t        ctl,
  input  logic [SW-1:0]              wr_addr,
  input  logic [bbrl_pkg::BLK_W-1:0] wr_block,
  input  logic [AW-1:0]              wr_start,
  input  logic [FW-1:0]              wr_size,
  input  logic [SW-1:0]              rd_addr,
  output logic                       rd_valid,
  output logic [bbrl_pkg::BLK_W-1:0] rd_block,
  output logic [AW-1:0]              rd_start,
  output logic [FW-1:0]              rd_size
);

  logic [bbrl_pkg::BLK_W-1:0] blk_mem [SLOT_COUNT];
  logic [AW-1:0]              start_mem [SLOT_COUNT];
  logic [FW-1:0]              size_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]      valid_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[rd_addr];
      if (ctl.clr_all) begin
        valid_r <= '0;
      end else if (ctl.wr) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (ctl.clr) begin
        valid_r[wr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      blk_mem[wr_addr]   <= wr_block;
      start_mem[wr_addr] <= wr_start;
      size_mem[wr_addr]  <= wr_size;
    end
    rd_block <= blk_mem[rd_addr];
    rd_start <= start_mem[rd_addr];
    rd_size  <= size_mem[rd_addr];
  end

  assign rd_valid = rd_valid_r;

endmodule

/* hw/rtl/bbrl_ring.sv */
// record ring memory, one write and one registered read port
module bbrl_ring #(
  parameter int unsigned RING_RECORDS = 4096,
  parameter int unsigned RECORD_BITS = 64,
  localparam int unsigned AW = $clog2(RING_RECORDS)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [RECORD_BITS-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [RECORD_BITS-1:0] rd_data
);

  logic [RECORD_BITS-1:0] mem [RING_RECORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/block_batch_ring_log.sv */
// block batch ring log: per-block record batches in a shared ring
//
// in channel: one beat per item; in_tuser carries the operation (begin batch,
// record, query count, read record), in_tdata the block number, batch count,
// record index and record word. out channel: exactly one beat per item with
// the status in out_tuser and counts, record and range in out_tdata.
// in_tready is high only while the sequencer is idle; one item at a time.
// record and rejected begin items go from idle straight to the output state.
// query and read items get the slot index from the remainder unit (taken
// at once for a power-of-two slot count, else found MOD_STEP bits a step)
// and then read the slot memory; a read adds a ring memory read.
// a begin adds a slot state and a check and update per oldest block evicted.
// reset empties all slots at once through their valid bits.
// the result sits in an output register; a new item is accepted while it
// waits, but the next result waits until out_tready takes the held beat.
module block_batch_ring_log #(
  parameter int unsigned SLOT_COUNT = 64,
  parameter int unsigned RING_RECORDS = 4096,
  parameter int unsigned RECORD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // operation
  input  logic [bbrl_pkg::OP_W-1:0]       in_tuser,
  // block_number, batch_count, record_index, record_word
  input  logic [bbrl_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status
  output logic [bbrl_pkg::STAT_W-1:0]     out_tuser,
  // held_count, record_out, free_space, range_valid, first_block, last_block
  output logic [bbrl_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned AW = $clog2(RING_RECORDS);
  localparam int unsigned FW = $clog2(RING_RECORDS + 1);
  localparam int unsigned GW = $clog2(SLOT_COUNT + 2);
  localparam int unsigned BW = bbrl_pkg::BLK_W;
  localparam int unsigned CW = bbrl_pkg::CNT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MODW  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SLOT  = 4'd3;
  localparam logic [3:0] S_EVCHK = 4'd4;
  localparam logic [3:0] S_EVUPD = 4'd5;
  localparam logic [3:0] S_COMM  = 4'd6;
  localparam logic [3:0] S_RRD   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]                  state_r, state_nxt;
  logic [bbrl_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [BW-1:0]               blk_r, blk_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [bbrl_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [SW-1:0]               s_r, s_nxt, oslot_r, oslot_nxt;
  logic [BW-1:0]               oldest_r, oldest_nxt, newest_r, newest_nxt;
  logic [AW-1:0]               wp_r, wp_nxt;
  logic [FW-1:0]               free_r, free_nxt;
  logic [CW-1:0]               pend_r, pend_nxt;
  logic                        drop_r, drop_nxt, set_old_r, set_old_nxt;
  logic [GW-1:0]               guard_r, guard_nxt;
  logic [bbrl_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [FW-1:0]               held_r, held_nxt;
  logic [bbrl_pkg::WORD_W-1:0] rec_r, rec_nxt;
  logic                        ov_r, ov_nxt;
  logic [bbrl_pkg::STAT_W-1:0] ostat_r, ostat_nxt;
  logic [bbrl_pkg::COUNT_W-1:0] oheld_r, oheld_nxt, ofree_r, ofree_nxt;
  logic [bbrl_pkg::WORD_W-1:0] orec_r, orec_nxt;
  logic                        orv_r, orv_nxt;
  logic [BW-1:0]               ofirst_r, ofirst_nxt, olast_r, olast_nxt;

  logic                        in_acc;
  logic [bbrl_pkg::OP_W-1:0]   f_op;
  logic [BW-1:0]               f_blk;
  logic [CW-1:0]               f_cnt;
  logic [bbrl_pkg::IDX_W-1:0]  f_idx;
  logic [RECORD_BITS-1:0]      f_word;
  logic                        reject, big;
  logic [17:0]                 pos_d, wp_sum, rd_sum;
  logic [AW-1:0]               rec_pos, wp_wrap, ring_raddr;
  logic                        short;

  logic                        mod_start, mod_done;
  logic [SW-1:0]               mod_rem;

  bbrl_pkg::slot_ctl_t         sctl;
  logic [SW-1:0]               s_waddr, s_raddr;
  logic                        s_rvalid;
  logic [BW-1:0]               s_rblock;
  logic [AW-1:0]               s_rstart;
  logic [FW-1:0]               s_rsize;
  logic                        held, idx_ok, sub_pend;
  logic [FW-1:0]               filled;

  logic                        r_wen, r_ren;
  logic [RECORD_BITS-1:0]      r_rdata;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign f_op      = in_tuser;
  assign f_blk     = in_tdata[63:0];
  assign f_cnt     = in_tdata[79:64];
  assign f_idx     = in_tdata[91:80];
  assign f_word    = in_tdata[92 +: RECORD_BITS];

  assign big    = {1'b0, f_cnt} > 17'(RING_RECORDS);
  assign reject = (f_blk == bbrl_pkg::NO_BLOCK) || (pend_r != '0) ||
                  ((newest_r != bbrl_pkg::NO_BLOCK) && (newest_r + 1'b1 != f_blk));

  assign pos_d   = 18'(wp_r) - 18'(pend_r);
  assign rec_pos = pos_d[17] ? AW'(pos_d + 18'(RING_RECORDS)) : AW'(pos_d);
  assign wp_sum  = 18'(wp_r) + 18'(cnt_r);
  assign wp_wrap = (wp_sum >= 18'(RING_RECORDS)) ? AW'(wp_sum - 18'(RING_RECORDS))
                                                 : AW'(wp_sum);
  assign short   = 17'(free_r) < 17'(cnt_r);

  assign held     = (blk_r != bbrl_pkg::NO_BLOCK) && s_rvalid && (s_rblock == blk_r);
  assign sub_pend = (blk_r == newest_r) && !drop_r && (17'(pend_r) <= 17'(s_rsize));
  assign filled   = sub_pend ? s_rsize - FW'(pend_r) : s_rsize;
  assign idx_ok   = 17'(idx_r) < 17'(filled);
  assign rd_sum   = 18'(s_rstart) + 18'(idx_r);
  assign ring_raddr = (rd_sum >= 18'(RING_RECORDS)) ? AW'(rd_sum - 18'(RING_RECORDS))
                                                    : AW'(rd_sum);

  assign s_raddr = (state_r == S_EVCHK) ? oslot_r : s_r;
  assign s_waddr = (state_r == S_EVUPD) ? oslot_r : s_r;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    blk_nxt     = blk_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    s_nxt       = s_r;
    oslot_nxt   = oslot_r;
    oldest_nxt  = oldest_r;
    newest_nxt  = newest_r;
    wp_nxt      = wp_r;
    free_nxt    = free_r;
    pend_nxt    = pend_r;
    drop_nxt    = drop_r;
    set_old_nxt = set_old_r;
    guard_nxt   = guard_r;
    stat_nxt    = stat_r;
    held_nxt    = held_r;
    rec_nxt     = rec_r;
    ov_nxt      = ov_r;
    ostat_nxt   = ostat_r;
    oheld_nxt   = oheld_r;
    orec_nxt    = orec_r;
    ofree_nxt   = ofree_r;
    orv_nxt     = orv_r;
    ofirst_nxt  = ofirst_r;
    olast_nxt   = olast_r;
    mod_start   = 1'b0;
    sctl        = '0;
    r_wen       = 1'b0;
    r_ren       = 1'b0;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = f_op;
          blk_nxt  = f_blk;
          cnt_nxt  = f_cnt;
          idx_nxt  = f_idx;
          held_nxt = '0;
          rec_nxt  = '0;
          stat_nxt = bbrl_pkg::ST_OK;
          case (f_op)
            bbrl_pkg::OP_BEGIN: begin
              if (reject) begin
                stat_nxt  = bbrl_pkg::ST_REJ;
                state_nxt = S_OUT;
              end else if (big) begin
                newest_nxt   = f_blk;
                sctl.clr_all = 1'b1;
                free_nxt     = FW'(RING_RECORDS);
                oldest_nxt   = bbrl_pkg::NO_BLOCK;
                pend_nxt     = f_cnt;
                drop_nxt     = 1'b1;
                stat_nxt     = bbrl_pkg::ST_DROP;
                state_nxt    = S_OUT;
              end else begin
                newest_nxt  = f_blk;
                set_old_nxt = (oldest_r == bbrl_pkg::NO_BLOCK);
                if (oldest_r == bbrl_pkg::NO_BLOCK) begin
                  oldest_nxt = f_blk;
                end
                guard_nxt = '0;
                mod_start = 1'b1;
                state_nxt = S_MODW;
              end
            end
            bbrl_pkg::OP_RECORD: begin
              state_nxt = S_OUT;
              if (pend_r == '0) begin
                stat_nxt = bbrl_pkg::ST_REJ;
              end else if (drop_r) begin
                pend_nxt = pend_r - 1'b1;
                if (pend_r == CW'(1)) begin
                  drop_nxt = 1'b0;
                end
                stat_nxt = bbrl_pkg::ST_DROP;
              end else begin
                r_wen    = 1'b1;
                pend_nxt = pend_r - 1'b1;
              end
            end
            default: begin
              set_old_nxt = 1'b0;
              mod_start   = 1'b1;
              state_nxt   = S_MODW;
            end
          endcase
        end
      end
      S_MODW: begin
        if (mod_done) begin
          s_nxt = mod_rem;
          if (set_old_r) begin
            oslot_nxt = mod_rem;
          end
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        case (op_r)
          bbrl_pkg::OP_BEGIN: begin
            if (s_rvalid) begin
              free_nxt = free_r + s_rsize;
              sctl.clr = 1'b1;
            end
            state_nxt = S_EVCHK;
          end
          bbrl_pkg::OP_QUERY: begin
            stat_nxt  = held ? bbrl_pkg::ST_OK : bbrl_pkg::ST_NONE;
            held_nxt  = held ? s_rsize : '0;
            state_nxt = S_OUT;
          end
          default: begin
            if (held && idx_ok) begin
              r_ren     = 1'b1;
              held_nxt  = s_rsize;
              state_nxt = S_RRD;
            end else begin
              stat_nxt  = bbrl_pkg::ST_NONE;
              state_nxt = S_OUT;
            end
          end
        endcase
      end
      S_EVCHK: begin
        if (short && (oldest_r < newest_r) && (guard_r <= GW'(SLOT_COUNT))) begin
          state_nxt = S_EVUPD;
        end else begin
          state_nxt = S_COMM;
        end
      end
      S_EVUPD: begin
        if (s_rvalid) begin
          free_nxt = free_r + s_rsize;
          sctl.clr = 1'b1;
        end
        oldest_nxt = oldest_r + 1'b1;
        oslot_nxt  = (oslot_r == SW'(SLOT_COUNT - 1)) ? '0 : oslot_r + 1'b1;
        guard_nxt  = guard_r + 1'b1;
        state_nxt  = S_EVCHK;
      end
      S_COMM: begin
        if (short) begin
          stat_nxt = bbrl_pkg::ST_REJ;
        end else begin
          sctl.wr  = 1'b1;
          wp_nxt   = wp_wrap;
          free_nxt = free_r - FW'(cnt_r);
          pend_nxt = cnt_r;
          drop_nxt = 1'b0;
        end
        state_nxt = S_OUT;
      end
      S_RRD: begin
        rec_nxt   = bbrl_pkg::WORD_W'(r_rdata);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt     = 1'b1;
          ostat_nxt  = stat_r;
          oheld_nxt  = bbrl_pkg::COUNT_W'(32'(held_r));
          orec_nxt   = rec_r;
          ofree_nxt  = bbrl_pkg::COUNT_W'(32'(free_r));
          orv_nxt    = (oldest_r != bbrl_pkg::NO_BLOCK);
          ofirst_nxt = oldest_r;
          olast_nxt  = newest_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      oldest_r  <= bbrl_pkg::NO_BLOCK;
      newest_r  <= bbrl_pkg::NO_BLOCK;
      wp_r      <= '0;
      free_r    <= FW'(RING_RECORDS);
      pend_r    <= '0;
      drop_r    <= 1'b0;
      set_old_r <= 1'b0;
      guard_r   <= '0;
      ov_r      <= 1'b0;
      oslot_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      oldest_r  <= oldest_nxt;
      newest_r  <= newest_nxt;
      wp_r      <= wp_nxt;
      free_r    <= free_nxt;
      pend_r    <= pend_nxt;
      drop_r    <= drop_nxt;
      set_old_r <= set_old_nxt;
      guard_r   <= guard_nxt;
      ov_r      <= ov_nxt;
      oslot_r   <= oslot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    blk_r    <= blk_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    s_r      <= s_nxt;
    stat_r   <= stat_nxt;
    held_r   <= held_nxt;
    rec_r    <= rec_nxt;
    ostat_r  <= ostat_nxt;
    oheld_r  <= oheld_nxt;
    orec_r   <= orec_nxt;
    ofree_r  <= ofree_nxt;
    orv_r    <= orv_nxt;
    ofirst_r <= ofirst_nxt;
    olast_r  <= olast_nxt;
  end

  bbrl_mod #(
    .DIVISOR(SLOT_COUNT)
  ) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mod_start),
    .value(in_acc ? f_blk : blk_r),
    .done (mod_done),
    .rem  (mod_rem)
  );

  bbrl_slot_tbl #(
    .SLOT_COUNT  (SLOT_COUNT),
    .RING_RECORDS(RING_RECORDS)
  ) u_slot (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sctl),
    .wr_addr (s_waddr),
    .wr_block(blk_r),
    .wr_start(wp_r),
    .wr_size (FW'(cnt_r)),
    .rd_addr (s_raddr),
    .rd_valid(s_rvalid),
    .rd_block(s_rblock),
    .rd_start(s_rstart),
    .rd_size (s_rsize)
  );

  bbrl_ring #(
    .RING_RECORDS(RING_RECORDS),
    .RECORD_BITS (RECORD_BITS)
  ) u_ring (
    .clk    (clk),
    .wr_en  (r_wen),
    .wr_addr(rec_pos),
    .wr_data(f_word),
    .rd_en  (r_ren),
    .rd_addr(ring_raddr),
    .rd_data(r_rdata)
  );

  assign out_tvalid = ov_r;
  assign out_tuser  = ostat_r;
  assign out_tdata  = {5'b0, olast_r, ofirst_r, orv_r, ofree_r, orec_r, oheld_r};

endmodule

/* hw/rtl/bbrl_chk.sv */
// port checker for the block batch ring log, bound to the top level
`include "block_batch_ring_log_assert.svh"

module bbrl_chk #(
  parameter int unsigned RING_RECORDS = 4096
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [bbrl_pkg::OP_W-1:0]       in_tuser,
  input logic [bbrl_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bbrl_pkg::STAT_W-1:0]     out_tuser,
  input logic [bbrl_pkg::OUT_DATA_W-1:0] out_tdata
);

  `BBRL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled out beat changed")

  `BBRL_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready,
    "in beat accepted while busy")

  `BBRL_ASSERT_SAME(a_no_range, out_tvalid && !out_tdata[90],
    out_tdata[154:91] == bbrl_pkg::NO_BLOCK, "empty range with first block set")

  `BBRL_ASSERT_SAME(a_free_max, out_tvalid,
    32'(out_tdata[89:77]) <= RING_RECORDS, "free space beyond ring size")

endmodule

bind block_batch_ring_log bbrl_chk #(.RING_RECORDS(RING_RECORDS)) u_bbrl_chk (.*);
